[sv/b64d_pkg.sv]
// Shared types, codes and the alphabet lookup for the base64 stream decoder.
// No dependencies; every other file of the decoder refers to this package by scoped names.
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_CHR = 2'd1;
	localparam logic [1:0] ST_BAD_PAD = 2'd2;
	localparam logic [1:0] ST_BAD_LEN = 2'd3;

	localparam logic [1:0] PH_NORMAL  = 2'd0;
	localparam logic [1:0] PH_AWAIT   = 2'd1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic            valid;
		logic [1:0]      status;
		logic            last;
	} entry_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t r;
		r.ok = 1'b1;
		r.val = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.val = 6'(c - 8'd65);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.val = 6'(c - 8'd71);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 6'(c + 8'd4);
		end else if (c == 8'h2B) begin
			r.val = 6'd62;
		end else if (c == 8'h2F) begin
			r.val = 6'd63;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

[sv/b64d_front.sv]
// Front end: accepts characters, tracks group position, padding and errors,
// and forms one result group per character that closes bytes or ends the stream. Uses b64d_pkg.
module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [7:0]          char_code,
	input  logic                last_char,
	output logic                ent_push,
	output b64d_pkg::entry_t    ent
);

	logic [1:0]  pos_q, pos_n;
	logic [17:0] held_q, held_n;
	logic [1:0]  phase_q, phase_n;
	logic [1:0]  err_q, err_n;
	logic [1:0]  nb;
	logic [2:0][7:0] b;
	b64d_pkg::sextet_t sx;
	logic        is_pad;

	assign sx = b64d_pkg::sextet_of(char_code);
	assign is_pad = char_code == b64d_pkg::PAD_CHAR;

	always_comb begin
		err_n = err_q;
		pos_n = pos_q;
		held_n = held_q;
		phase_n = phase_q;
		nb = 2'd0;
		b = '0;
		if (err_q == b64d_pkg::ST_OK) begin
			priority if (phase_q == b64d_pkg::PH_AWAIT) begin
				priority if (!is_pad && !sx.ok) begin
					err_n = b64d_pkg::ST_BAD_CHR;
				end else if (!is_pad || !last_char) begin
					err_n = b64d_pkg::ST_BAD_PAD;
				end else begin
					nb = 2'd1;
					b[0] = held_q[11:4];
				end
			end else if (!is_pad && !sx.ok) begin
				err_n = b64d_pkg::ST_BAD_CHR;
			end else if (is_pad) begin
				priority if (pos_q < 2'd2) begin
					err_n = b64d_pkg::ST_BAD_PAD;
				end else if (pos_q == 2'd2) begin
					if (last_char) begin
						err_n = b64d_pkg::ST_BAD_LEN;
					end else begin
						phase_n = b64d_pkg::PH_AWAIT;
					end
				end else if (!last_char) begin
					err_n = b64d_pkg::ST_BAD_PAD;
				end else begin
					nb = 2'd2;
					b[0] = held_q[17:10];
					b[1] = held_q[9:2];
				end
			end else if (pos_q == 2'd3) begin
				nb = 2'd3;
				b[0] = held_q[17:10];
				b[1] = held_q[9:2];
				b[2] = {held_q[1:0], sx.val};
				held_n = '0;
				pos_n = 2'd0;
			end else begin
				held_n = {held_q[11:0], sx.val};
				pos_n = pos_q + 2'd1;
				if (last_char) begin
					err_n = b64d_pkg::ST_BAD_LEN;
				end
			end
		end
	end

	always_comb begin
		ent.last = last_char;
		if (last_char && (err_n != b64d_pkg::ST_OK || nb == 2'd0)) begin
			ent.cnt = 2'd1;
			ent.bytes = '0;
			ent.valid = 1'b0;
			ent.status = err_n;
		end else begin
			ent.cnt = nb;
			ent.bytes = b;
			ent.valid = 1'b1;
			ent.status = b64d_pkg::ST_OK;
		end
	end

	assign ent_push = acc && (last_char || (nb != 2'd0 && err_n == b64d_pkg::ST_OK));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			held_q <= '0;
			phase_q <= b64d_pkg::PH_NORMAL;
			err_q <= b64d_pkg::ST_OK;
		end else if (acc) begin
			if (last_char) begin
				pos_q <= '0;
				held_q <= '0;
				phase_q <= b64d_pkg::PH_NORMAL;
				err_q <= b64d_pkg::ST_OK;
			end else begin
				pos_q <= pos_n;
				held_q <= held_n;
				phase_q <= phase_n;
				err_q <= err_n;
			end
		end
	end

	a_reset_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_char |=> pos_q == 2'd0 && err_q == b64d_pkg::ST_OK
			&& phase_q == b64d_pkg::PH_NORMAL)
		else $error("stream state not cleared after last item");
	a_await_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == b64d_pkg::PH_AWAIT |-> pos_q == 2'd2)
		else $error("padding wait outside third position");

endmodule

[sv/b64d_queue.sv]
// Short queue of result groups between the front and back ends.
// Depends on b64d_pkg for the entry type and depth.
module b64d_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  b64d_pkg::entry_t    wdata,
	input  logic                rd,
	output b64d_pkg::entry_t    rdata,
	output logic                q_full,
	output logic                q_empty
);

	b64d_pkg::entry_t mem_q [b64d_pkg::QDEPTH];
	logic [b64d_pkg::QPTR_W-1:0] head_q, tail_q;
	logic [b64d_pkg::QCNT_W-1:0] cnt_q;

	assign q_full = cnt_q == b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH);
	assign q_empty = cnt_q == '0;
	assign rdata = mem_q[head_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[tail_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				tail_q <= tail_q + 1'b1;
			end
			if (rd) begin
				head_q <= head_q + 1'b1;
			end
			cnt_q <= cnt_q + b64d_pkg::QCNT_W'(wr) - b64d_pkg::QCNT_W'(rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !q_full || rd)
		else $error("write into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> !q_empty)
		else $error("read from empty queue");

endmodule

[sv/b64d_back.sv]
// Back end: holds one result group and hands out its results one per pop.
// Depends on b64d_pkg for the entry type.
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  b64d_pkg::entry_t    q_data,
	output logic                q_rd,
	input  logic                pop,
	output logic                empty,
	output logic [7:0]          data_byte,
	output logic                byte_valid,
	output logic [1:0]          status,
	output logic                last_result
);

	b64d_pkg::entry_t cur_q;
	logic             cur_valid_q;
	logic [1:0]       idx_q;
	logic             at_end;
	logic             take;

	assign at_end = idx_q == cur_q.cnt - 2'd1;
	assign take = pop && cur_valid_q;
	assign q_rd = !q_empty && (!cur_valid_q || (take && at_end));

	assign empty = !cur_valid_q;
	assign data_byte = cur_q.bytes[idx_q];
	assign byte_valid = cur_q.valid;
	assign status = at_end ? cur_q.status : b64d_pkg::ST_OK;
	assign last_result = cur_q.last && at_end;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q <= '0;
		end else if (q_rd) begin
			cur_valid_q <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			if (at_end) begin
				cur_valid_q <= 1'b0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> idx_q < cur_q.cnt)
		else $error("result index beyond group size");

endmodule

[sv/base64_stream_decoder_core.sv]
// Top level of the base64 stream decoder: front end, group queue and back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// One character is taken per clock while full is low; full rises only when the
// four-entry group queue between the front and back ends is full. Each character
// that closes a group (or ends the stream) becomes one queue entry of up to three
// results, and the back end delivers one result per cycle with pop while not
// empty. Since four characters give at most three bytes, the sustained rate is
// one character per cycle when pop is held high; each group is registered in the
// queue and again in the back end. Errors are reported once, on the result that
// carries last_result, and any bytes delivered earlier in that stream are void.
module base64_stream_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] char_code,
	input  logic       last_char,
	input  logic       push,
	output logic       full,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic [1:0] status,
	output logic       last_result,
	output logic       empty,
	input  logic       pop
);

	logic             acc;
	logic             ent_push;
	b64d_pkg::entry_t ent;
	b64d_pkg::entry_t q_data;
	logic             q_rd;
	logic             q_empty;

	assign acc = push && !full;

	b64d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.char_code (char_code),
		.last_char (last_char),
		.ent_push  (ent_push),
		.ent       (ent)
	);

	b64d_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (ent_push),
		.wdata   (ent),
		.rd      (q_rd),
		.rdata   (q_data),
		.q_full  (full),
		.q_empty (q_empty)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.status      (status),
		.last_result (last_result)
	);

endmodule
